// File: rtl/core/thumbnail_pixel_decimator_macros.svh
// assertion macros for the thumbnail pixel decimator checker
`ifndef THUMBNAIL_PIXEL_DECIMATOR_MACROS_SVH
`define THUMBNAIL_PIXEL_DECIMATOR_MACROS_SVH

// same-cycle implication
`define TPD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/tpd_pkg.sv
// types and constants shared by the thumbnail pixel decimator
package tpd_pkg;

	localparam int unsigned DIM_W     = 13;
	localparam int unsigned CNT_W     = 12;
	localparam int unsigned STEP_W    = 8;
	localparam int unsigned SCALE_W   = 7;
	localparam int unsigned CFG_W     = 13;
	localparam int unsigned IDX_W     = 2;
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned DIV_CNT_W = $clog2(DIM_W + 1);

	localparam logic [DIM_W-1:0]   MAX_DIM      = 13'd4096;
	localparam logic [DIM_W-1:0]   RST_WIDTH    = 13'd640;
	localparam logic [DIM_W-1:0]   RST_HEIGHT   = 13'd480;
	localparam logic [SCALE_W-1:0] RST_SCALE    = 7'd4;
	localparam logic               RST_MONO     = 1'b0;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_SCALE_FACTOR,
		REG_COLOR_MODE
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_OUT_W,
		ST_OUT_H,
		ST_STEP_H,
		ST_STEP_V
	} setup_state_t;

	typedef struct packed {
		logic [PIX_W-1:0] chan_blue;
		logic [PIX_W-1:0] chan_green;
		logic [PIX_W-1:0] chan_red;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_blue;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_red;
		logic             row_end;
		logic             frame_end;
	} thumb_t;

	typedef struct packed {
		logic [DIM_W-1:0]  out_w;
		logic [DIM_W-1:0]  out_h;
		logic [STEP_W-1:0] h_step;
		logic [STEP_W-1:0] v_step;
		logic [DIM_W-1:0]  eff_w;
		logic [DIM_W-1:0]  eff_h;
		logic              mono;
	} geom_t;

endpackage

// File: rtl/core/tpd_div.sv
// restoring divider, one quotient bit per cycle
module tpd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tpd_pkg::DIM_W-1:0] dividend,
	input  logic [tpd_pkg::DIM_W-1:0] divisor,
	output logic                      done,
	output logic [tpd_pkg::DIM_W-1:0] quotient
);
	import tpd_pkg::*;

	logic [DIM_W-1:0]     num_q;
	logic [DIM_W-1:0]     rem_q;
	logic [DIM_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIM_W:0]       rem_sh;
	logic [DIM_W:0]       rem_nx;
	logic                 fits;

	always_comb begin
		rem_sh = {rem_q, num_q[DIM_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
		rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(DIM_W);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q  <= cnt_q - 1'b1;
			run_q  <= cnt_q != DIV_CNT_W'(1);
			done_q <= cnt_q == DIV_CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			num_q <= {num_q[DIM_W-2:0], fits};
			rem_q <= rem_nx[DIM_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// File: rtl/core/tpd_setup.sv
// configuration registers and thumbnail geometry sequencer
module tpd_setup (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  tpd_pkg::cfg_idx_t         cfg_index,
	input  logic [tpd_pkg::CFG_W-1:0] cfg_data,
	output tpd_pkg::geom_t            geom,
	output logic                      busy,
	output logic                      load
);
	import tpd_pkg::*;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [SCALE_W-1:0] scale_q;
	logic               mono_q;
	setup_state_t       state_q;
	setup_state_t       state_nx;
	logic [DIM_W-1:0]   out_w_q;
	logic [DIM_W-1:0]   out_h_q;
	logic [STEP_W-1:0]  h_step_q;
	logic [STEP_W-1:0]  v_step_q;

	logic [DIM_W-1:0]   w_cl;
	logic [DIM_W-1:0]   h_cl;
	logic [DIM_W-1:0]   scale_ext;
	logic               div_start;
	logic [DIM_W-1:0]   div_dividend;
	logic [DIM_W-1:0]   div_divisor;
	logic               div_done;
	logic [DIM_W-1:0]   div_quot;
	logic [DIM_W-1:0]   quot_by_scale;
	logic [STEP_W-1:0]  step_h_nx;
	logic [STEP_W-1:0]  step_v_nx;

	tpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			scale_q  <= RST_SCALE;
			mono_q   <= RST_MONO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				REG_SCALE_FACTOR: scale_q  <= cfg_data[SCALE_W-1:0];
				REG_COLOR_MODE:   mono_q   <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		w_cl          = (width_q > MAX_DIM) ? MAX_DIM : width_q;
		h_cl          = (height_q > MAX_DIM) ? MAX_DIM : height_q;
		scale_ext     = DIM_W'(scale_q);
		quot_by_scale = (scale_q == '0) ? '0 : div_quot;
		// step below twice the scale, so it fits the narrow step field
		step_h_nx     = mono_q ? ((out_w_q == '0) ? '0 : div_quot[STEP_W-1:0])
			: STEP_W'(scale_q);
		step_v_nx     = mono_q ? ((out_h_q == '0) ? '0 : div_quot[STEP_W-1:0])
			: STEP_W'(scale_q);
	end

	always_comb begin
		state_nx     = state_q;
		div_start    = 1'b0;
		div_dividend = w_cl;
		div_divisor  = scale_ext;
		load         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_START: begin
				div_start = 1'b1;
				state_nx  = ST_OUT_W;
			end
			ST_OUT_W: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = h_cl;
					state_nx     = ST_OUT_H;
				end
			end
			ST_OUT_H: begin
				if (div_done) begin
					div_start   = 1'b1;
					div_divisor = out_w_q;
					state_nx    = ST_STEP_H;
				end
			end
			ST_STEP_H: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = h_cl;
					div_divisor  = out_h_q;
					state_nx     = ST_STEP_V;
				end
			end
			ST_STEP_V: begin
				if (div_done) begin
					load     = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_START;
		endcase
		if (cfg_we) begin
			load     = 1'b0;
			state_nx = ST_START;
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			if (state_q == ST_OUT_W) begin
				out_w_q <= quot_by_scale;
			end
			if (state_q == ST_OUT_H) begin
				out_h_q <= quot_by_scale;
			end
			if (state_q == ST_STEP_H) begin
				h_step_q <= step_h_nx;
			end
			if (state_q == ST_STEP_V) begin
				v_step_q <= step_v_nx;
			end
		end
	end

	always_comb begin
		geom.out_w  = out_w_q;
		geom.out_h  = out_h_q;
		geom.h_step = h_step_q;
		geom.v_step = (state_q == ST_STEP_V) ? step_v_nx : v_step_q;
		geom.eff_w  = (w_cl == '0) ? DIM_W'(1) : w_cl;
		geom.eff_h  = (h_cl == '0) ? DIM_W'(1) : h_cl;
		geom.mono   = mono_q;
	end

	assign busy = state_q != ST_IDLE;

endmodule

// File: rtl/core/tpd_sampler.sv
// input register, raster counters, sample decision and result register
module tpd_sampler (
	input  logic           clk,
	input  logic           arst_n,
	input  tpd_pkg::geom_t geom,
	input  logic           load,
	input  logic           busy,
	input  logic           pix_valid,
	output logic           pix_stall,
	input  tpd_pkg::pix_t  pix,
	output logic           thumb_valid,
	input  logic           thumb_stall,
	output tpd_pkg::thumb_t thumb
);
	import tpd_pkg::*;

	pix_t             pix_s1;
	logic             valid_s1;
	thumb_t           thumb_s2;
	logic             valid_s2;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [DIM_W-1:0] nsc_q;
	logic [DIM_W-1:0] nsr_q;
	logic [DIM_W-1:0] cole_q;
	logic [DIM_W-1:0] rowe_q;

	logic             accept;
	logic             advance;
	logic             row_hit;
	logic             hit;
	logic             last_col;
	logic             last_row;
	logic [DIM_W-1:0] col_nx;
	logic [DIM_W-1:0] row_nx;
	logic             col_wrap;
	logic             row_wrap;

	always_comb begin
		accept    = pix_valid && !pix_stall;
		advance   = valid_s1 && (!valid_s2 || !thumb_stall);
		pix_stall = busy || (valid_s1 && !advance);
		row_hit   = ({1'b0, row_q} == nsr_q) && (rowe_q < geom.out_h);
		hit       = row_hit && ({1'b0, col_q} == nsc_q) && (cole_q < geom.out_w);
		last_col  = (cole_q + DIM_W'(1)) == geom.out_w;
		last_row  = (rowe_q + DIM_W'(1)) == geom.out_h;
		col_nx    = {1'b0, col_q} + DIM_W'(1);
		row_nx    = {1'b0, row_q} + DIM_W'(1);
		col_wrap  = col_nx >= geom.eff_w;
		row_wrap  = row_nx >= geom.eff_h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix;
		end
	end

	// frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			nsc_q  <= '0;
			nsr_q  <= '0;
			cole_q <= '0;
			rowe_q <= '0;
		end else if (load) begin
			col_q  <= '0;
			row_q  <= '0;
			cole_q <= '0;
			rowe_q <= '0;
			nsc_q  <= DIM_W'(geom.h_step >> 1);
			nsr_q  <= DIM_W'(geom.v_step >> 1);
		end else if (advance) begin
			if (col_wrap) begin
				col_q  <= '0;
				cole_q <= '0;
				nsc_q  <= DIM_W'(geom.h_step >> 1);
				if (row_wrap) begin
					row_q  <= '0;
					rowe_q <= '0;
					nsr_q  <= DIM_W'(geom.v_step >> 1);
				end else begin
					row_q <= row_nx[CNT_W-1:0];
					if (row_hit) begin
						rowe_q <= rowe_q + DIM_W'(1);
						nsr_q  <= nsr_q + DIM_W'(geom.v_step);
					end
				end
			end else begin
				col_q <= col_nx[CNT_W-1:0];
				if (hit) begin
					cole_q <= cole_q + DIM_W'(1);
					nsc_q  <= nsc_q + DIM_W'(geom.h_step);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= hit;
		end else if (!thumb_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			thumb_s2.out_blue  <= pix_s1.chan_blue;
			thumb_s2.out_green <= geom.mono ? '0 : pix_s1.chan_green;
			thumb_s2.out_red   <= geom.mono ? '0 : pix_s1.chan_red;
			thumb_s2.row_end   <= last_col;
			thumb_s2.frame_end <= last_col && last_row;
		end
	end

	assign thumb_valid = valid_s2;
	assign thumb       = thumb_s2;

endmodule

// File: rtl/core/thumbnail_pixel_decimator.sv
// top level of the point-sampling thumbnail decimator
//
//  channel  signals                          direction  transfer when
//  pix      pix_valid pix_stall pix          in         pix_valid & !pix_stall
//  thumb    thumb_valid thumb_stall thumb    out        thumb_valid & !thumb_stall
//  cfg      cfg_we cfg_index cfg_data        in         cfg_we
//
//  one pixel per cycle unless stalled; a sampled pixel passes the input and result registers
//  the two registers are parted, so pix takes one more pixel while a result waits
//  after reset and after every register write the geometry sequencer runs a start state
//  and four divisions (out width, out height, h step, v step); pix_stall stays high meanwhile
//  thumb_stall holds the result register and, one pixel later, the input register
module thumbnail_pixel_decimator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pix_valid,
	output logic                      pix_stall,
	input  tpd_pkg::pix_t             pix,
	output logic                      thumb_valid,
	input  logic                      thumb_stall,
	output tpd_pkg::thumb_t           thumb,
	input  logic                      cfg_we,
	input  tpd_pkg::cfg_idx_t         cfg_index,
	input  logic [tpd_pkg::CFG_W-1:0] cfg_data
);
	import tpd_pkg::*;

	geom_t geom;
	logic  busy;
	logic  load;

	tpd_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.busy      (busy),
		.load      (load)
	);

	tpd_sampler u_sampler (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom),
		.load        (load),
		.busy        (busy),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pix         (pix),
		.thumb_valid (thumb_valid),
		.thumb_stall (thumb_stall),
		.thumb       (thumb)
	);

endmodule

// File: rtl/core/tpd_checker.sv
// port-level checks for the thumbnail decimator and their binding
`include "thumbnail_pixel_decimator_macros.svh"

module tpd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            pix_stall,
	input logic            thumb_valid,
	input logic            thumb_stall,
	input tpd_pkg::thumb_t thumb,
	input logic            cfg_we
);
	import tpd_pkg::*;

	`TPD_ASSERT_NXT(a_thumb_hold, clk, arst_n, thumb_valid && thumb_stall, thumb_valid, "thumb valid dropped while stalled")
	`TPD_ASSERT_NXT(a_thumb_stable, clk, arst_n, thumb_valid && thumb_stall, $stable(thumb), "thumb payload changed while stalled")
	`TPD_ASSERT_IMP(a_frame_row, clk, arst_n, thumb_valid && thumb.frame_end, thumb.row_end, "frame end without row end")
	`TPD_ASSERT_NXT(a_cfg_busy, clk, arst_n, cfg_we, pix_stall, "pixel taken during geometry setup")

endmodule

bind thumbnail_pixel_decimator tpd_checker u_tpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pix_stall   (pix_stall),
	.thumb_valid (thumb_valid),
	.thumb_stall (thumb_stall),
	.thumb       (thumb),
	.cfg_we      (cfg_we)
);
